// File: hdl/romaji_to_kana_converter_macros.svh
// ----------------------------------------------------------------------------
// romaji to kana converter assertion macros
// concurrent checks clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ROMAJI_TO_KANA_CONVERTER_MACROS_SVH
`define ROMAJI_TO_KANA_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RTK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RTK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RTK_ASSERT_IMP(lbl, ante, cons, msg)
`define RTK_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: hdl/rtk_pkg.sv
// ----------------------------------------------------------------------------
// rtk_pkg
// word types, key and row codes and the row transition tables of the
// romaji to kana converter
// ----------------------------------------------------------------------------
`default_nettype none

package rtk_pkg;

  localparam logic [4:0] KEY_H         = 5'd7;
  localparam logic [4:0] KEY_N         = 5'd13;
  localparam logic [4:0] KEY_Y         = 5'd24;
  localparam logic [4:0] KEY_BACKSPACE = 5'd26;
  localparam logic [4:0] KEY_SPACE     = 5'd27;
  localparam logic [4:0] KEY_LETTERS   = 5'd26;

  localparam logic [5:0] ROW_EMPTY = 6'd0;
  localparam logic [5:0] ROW_C     = 6'd3;
  localparam logic [5:0] ROW_N     = 6'd21;
  localparam logic [5:0] ROW_S     = 6'd28;
  localparam logic [5:0] ROW_LAST  = 6'd40;

  localparam logic [1:0] KIND_KANA  = 2'd0;
  localparam logic [1:0] KIND_SYL_N = 2'd1;
  localparam logic [1:0] KIND_LATIN = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [4:0] key_code;
    logic       key_pressed;
    logic       ctrl_held;
  } in_word_t;

  typedef struct packed {
    logic       commit_valid;
    logic [1:0] commit_kind;
    logic [5:0] commit_row;
    logic [2:0] commit_vowel;
    logic       preedit_valid;
    logic [5:0] preedit_row;
    logic       converter_on;
  } out_word_t;

  typedef struct packed {
    logic       enabled;
    logic [5:0] row;
  } state_t;

  typedef struct packed {
    logic       is_vowel;
    logic [2:0] col;
  } vowel_t;

  // row started by a consonant letter, empty for vowels
  function automatic logic [5:0] letter_row(input logic [4:0] code);
    logic [5:0] r;
    unique case (code)
      5'd1:    r = 6'd1;
      5'd2:    r = 6'd3;
      5'd3:    r = 6'd5;
      5'd5:    r = 6'd7;
      5'd6:    r = 6'd9;
      5'd7:    r = 6'd11;
      5'd9:    r = 6'd13;
      5'd10:   r = 6'd15;
      5'd11:   r = 6'd17;
      5'd12:   r = 6'd19;
      5'd13:   r = 6'd21;
      5'd15:   r = 6'd23;
      5'd16:   r = 6'd25;
      5'd17:   r = 6'd26;
      5'd18:   r = 6'd28;
      5'd19:   r = 6'd31;
      5'd21:   r = 6'd33;
      5'd22:   r = 6'd35;
      5'd23:   r = 6'd36;
      5'd24:   r = 6'd38;
      5'd25:   r = 6'd39;
      default: r = ROW_EMPTY;
    endcase
    return r;
  endfunction

  function automatic vowel_t vowel_col(input logic [4:0] code);
    vowel_t v;
    unique case (code)
      5'd0:    v = '{is_vowel: 1'b1, col: 3'd0};
      5'd8:    v = '{is_vowel: 1'b1, col: 3'd1};
      5'd20:   v = '{is_vowel: 1'b1, col: 3'd2};
      5'd4:    v = '{is_vowel: 1'b1, col: 3'd3};
      5'd14:   v = '{is_vowel: 1'b1, col: 3'd4};
      default: v = '{is_vowel: 1'b0, col: 3'd0};
    endcase
    return v;
  endfunction

  // row reached by typing y, empty if the row cannot take y
  function automatic logic [5:0] y_ext(input logic [5:0] row);
    logic [5:0] r;
    unique case (row)
      6'd1:    r = 6'd2;
      6'd5:    r = 6'd6;
      6'd7:    r = 6'd8;
      6'd9:    r = 6'd10;
      6'd11:   r = 6'd12;
      6'd13:   r = 6'd14;
      6'd15:   r = 6'd16;
      6'd17:   r = 6'd18;
      6'd19:   r = 6'd20;
      6'd21:   r = 6'd22;
      6'd23:   r = 6'd24;
      6'd26:   r = 6'd27;
      6'd28:   r = 6'd30;
      6'd31:   r = 6'd32;
      6'd33:   r = 6'd34;
      6'd36:   r = 6'd37;
      6'd39:   r = 6'd40;
      default: r = ROW_EMPTY;
    endcase
    return r;
  endfunction

  // row left after backspace
  function automatic logic [5:0] bs_parent(input logic [5:0] row);
    logic [5:0] r;
    unique case (row)
      6'd2:    r = 6'd1;
      6'd4:    r = 6'd3;
      6'd6:    r = 6'd5;
      6'd8:    r = 6'd7;
      6'd10:   r = 6'd9;
      6'd12:   r = 6'd11;
      6'd14:   r = 6'd13;
      6'd16:   r = 6'd15;
      6'd18:   r = 6'd17;
      6'd20:   r = 6'd19;
      6'd22:   r = 6'd21;
      6'd24:   r = 6'd23;
      6'd27:   r = 6'd26;
      6'd29:   r = 6'd28;
      6'd30:   r = 6'd28;
      6'd32:   r = 6'd31;
      6'd34:   r = 6'd33;
      6'd37:   r = 6'd36;
      6'd40:   r = 6'd39;
      default: r = ROW_EMPTY;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/rtk_step.sv
// ----------------------------------------------------------------------------
// rtk_step
// next state and result word for one key event
// ----------------------------------------------------------------------------
`default_nettype none

module rtk_step (
  input  rtk_pkg::state_t    st,
  input  rtk_pkg::in_word_t  word,
  output rtk_pkg::state_t    st_nxt,
  output logic               has_result,
  output rtk_pkg::out_word_t result
);

  rtk_pkg::vowel_t v;
  logic [5:0]      nrow;
  logic            commit;

  assign v = rtk_pkg::vowel_col(word.key_code);

  always_comb begin
    st_nxt     = st;
    has_result = 1'b0;
    result     = '0;
    nrow       = st.row;
    commit     = 1'b0;
    if (word.req_type) begin
      st_nxt = '0;
    end else if (!word.key_pressed) begin
      st_nxt = st;
    end else if (word.key_code == rtk_pkg::KEY_SPACE && word.ctrl_held) begin
      st_nxt.enabled      = !st.enabled;
      has_result          = 1'b1;
      result.converter_on = !st.enabled;
      if (st.enabled) begin
        // turning off drops the pending letters
        st_nxt.row           = rtk_pkg::ROW_EMPTY;
        result.preedit_valid = 1'b1;
      end
    end else if (st.enabled) begin
      has_result = 1'b1;
      if (word.key_code == rtk_pkg::KEY_BACKSPACE) begin
        nrow = rtk_pkg::bs_parent(st.row);
      end else if (word.key_code < rtk_pkg::KEY_LETTERS) begin
        if (word.key_code == rtk_pkg::KEY_Y &&
            rtk_pkg::y_ext(st.row) != rtk_pkg::ROW_EMPTY) begin
          nrow = rtk_pkg::y_ext(st.row);
        end else if (word.key_code == rtk_pkg::KEY_H &&
                     (st.row == rtk_pkg::ROW_C || st.row == rtk_pkg::ROW_S)) begin
          nrow = st.row + 6'd1;
        end else if (st.row == rtk_pkg::ROW_N) begin
          commit            = 1'b1;
          result.commit_row = rtk_pkg::ROW_N;
          if (v.is_vowel) begin
            result.commit_kind  = rtk_pkg::KIND_KANA;
            result.commit_vowel = v.col;
            nrow                = rtk_pkg::ROW_EMPTY;
          end else begin
            // syllabic n, a second n is swallowed
            result.commit_kind = rtk_pkg::KIND_SYL_N;
            nrow = (word.key_code == rtk_pkg::KEY_N) ? rtk_pkg::ROW_EMPTY
                                                     : rtk_pkg::letter_row(word.key_code);
          end
        end else if (v.is_vowel) begin
          commit              = 1'b1;
          result.commit_kind  = rtk_pkg::KIND_KANA;
          result.commit_row   = st.row;
          result.commit_vowel = v.col;
          nrow                = rtk_pkg::ROW_EMPTY;
        end else begin
          if (st.row != rtk_pkg::ROW_EMPTY) begin
            commit             = 1'b1;
            result.commit_kind = rtk_pkg::KIND_LATIN;
            result.commit_row  = st.row;
          end
          nrow = rtk_pkg::letter_row(word.key_code);
        end
      end
      st_nxt.row           = nrow;
      result.commit_valid  = commit;
      result.preedit_valid = (nrow != rtk_pkg::ROW_EMPTY) || !commit;
      result.preedit_row   = nrow;
      result.converter_on  = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rtk_out_queue.sv
// ----------------------------------------------------------------------------
// rtk_out_queue
// two-entry result queue between the key logic and the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module rtk_out_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rtk_pkg::out_word_t push_data,
  input  logic               out_stall,
  output logic               out_valid,
  output rtk_pkg::out_word_t out_data,
  output logic               full
);

  rtk_pkg::out_word_t q0_r;
  rtk_pkg::out_word_t q1_r;
  logic [1:0]         count_r;
  logic               pop;

  assign out_valid = (count_r != 2'd0);
  assign out_data  = q0_r;
  assign full      = (count_r == 2'd2);
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b11: begin
          if (count_r == 2'd1) begin
            q0_r <= push_data;
          end else begin
            q0_r <= q1_r;
            q1_r <= push_data;
          end
        end
        2'b01: begin
          q0_r    <= q1_r;
          count_r <= count_r - 2'd1;
        end
        2'b10: begin
          if (count_r == 2'd0) begin
            q0_r <= push_data;
          end else begin
            q1_r <= push_data;
          end
          count_r <= count_r + 2'd1;
        end
        default: begin
          count_r <= count_r;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/romaji_to_kana_converter.sv
// ----------------------------------------------------------------------------
// romaji_to_kana_converter
// romaji key events in, kana commit and preedit codes out
// ----------------------------------------------------------------------------
// in_data carries one key event word per accepted handshake (in_valid high,
// in_stall low). The on flag and pending row update at the accepting edge,
// so a new word can be taken every cycle: one word per cycle sustained
// while in_stall is low. Words that cause a result push it into a
// two-entry output queue; the result shows on out_data once the results
// ahead of it have left, and leaves when out_valid is high and out_stall is
// low. Reset events clear the on flag and pending row; they give no result
// word, nor do releases or non-toggle keys while off, which change nothing.
// When the receiver stalls, the queue holds up to two results; in_stall
// rises only while both entries are full. rst_n (synchronous, active low)
// empties the queue and clears the on flag and pending row.
// ----------------------------------------------------------------------------
`default_nettype none

`include "romaji_to_kana_converter_macros.svh"

module romaji_to_kana_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rtk_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rtk_pkg::out_word_t out_data
);

  rtk_pkg::state_t    state_r;
  rtk_pkg::state_t    state_nxt;
  rtk_pkg::out_word_t result;
  logic               has_result;
  logic               in_acc;
  logic               full;
  logic               row_empty;
  logic               state_cleared;
  logic               syl_n_out;
  logic               toggle_off_acc;

  assign in_stall = full;
  assign in_acc   = in_valid && !in_stall;

  rtk_step u_step (
    .st         (state_r),
    .word       (in_data),
    .st_nxt     (state_nxt),
    .has_result (has_result),
    .result     (result)
  );

  rtk_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc && has_result),
    .push_data (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (full)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  assign row_empty      = (state_r.row == rtk_pkg::ROW_EMPTY);
  assign state_cleared  = !state_r.enabled && row_empty;
  assign syl_n_out      = out_valid && out_data.commit_valid &&
                          out_data.commit_kind == rtk_pkg::KIND_SYL_N;
  assign toggle_off_acc = in_acc && !in_data.req_type && in_data.key_pressed &&
                          in_data.ctrl_held && in_data.key_code == rtk_pkg::KEY_SPACE &&
                          state_r.enabled;

  `RTK_ASSERT_IMP(a_off_empty, !state_r.enabled, row_empty, "pending row kept while off")
  `RTK_ASSERT_IMP(a_row_range, 1'b1, state_r.row <= rtk_pkg::ROW_LAST, "pending row out of range")
  `RTK_ASSERT_IMP(a_stall_full, in_stall, out_valid, "input stalled with no result queued")
  `RTK_ASSERT_IMP(a_syl_n_row, syl_n_out, out_data.commit_row == rtk_pkg::ROW_N, "syllabic n on wrong row")
  `RTK_ASSERT_NXT(a_toggle_off, toggle_off_acc, state_cleared, "toggle off did not clear state")

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the romaji to kana converter: directed key
// sequences, then romaji-shaped random typing with random idle and stall
// bursts, a long output hold and a full drain pause, every result word
// compared field by field against an in-bench model of the row state
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_WORDS   = 650;
  localparam int LONG_HOLD      = 40;
  localparam int HOLD_AFTER     = 300;
  localparam int TAIL_WORDS     = 60;

  localparam logic [4:0] KEY_A        = 5'd0;
  localparam logic [4:0] KEY_C        = 5'd2;
  localparam logic [4:0] KEY_E        = 5'd4;
  localparam logic [4:0] KEY_I        = 5'd8;
  localparam logic [4:0] KEY_K        = 5'd10;
  localparam logic [4:0] KEY_O        = 5'd14;
  localparam logic [4:0] KEY_U        = 5'd20;
  localparam logic [4:0] KEY_X        = 5'd23;
  localparam logic [4:0] KEY_Z        = 5'd25;
  localparam logic [4:0] KEY_SYMBOL   = 5'd28;
  localparam logic [4:0] KEY_CODE_MAX = 5'd31;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  rtk_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  rtk_pkg::out_word_t out_data;

  rtk_pkg::in_word_t  pending_keys[$];
  rtk_pkg::out_word_t kana_expected[$];

  // model state
  bit         conv_on;
  logic [5:0] cur_row;

  int send_gap;
  int recv_gap;
  int hold_left;
  bit long_hold_done;
  bit tail_phase;
  int keys_accepted;
  int results_checked;
  int mismatches;
  int idle_cycles;
  int kind_count[3];
  rtk_pkg::out_word_t want_word;

  romaji_to_kana_converter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic rtk_pkg::in_word_t key_word(input logic [4:0] code, input bit pressed,
                                                 input bit ctrl);
    rtk_pkg::in_word_t w;
    w = '0;
    w.key_code    = code;
    w.key_pressed = pressed;
    w.ctrl_held   = ctrl;
    return w;
  endfunction

  // row opened by a consonant; vowels and non-letters open nothing
  function automatic logic [5:0] row_of_letter(input logic [4:0] code);
    case (code)
      5'd1:  return 6'd1;   // b
      5'd2:  return 6'd3;   // c
      5'd3:  return 6'd5;   // d
      5'd5:  return 6'd7;   // f
      5'd6:  return 6'd9;   // g
      5'd7:  return 6'd11;  // h
      5'd9:  return 6'd13;  // j
      5'd10: return 6'd15;  // k
      5'd11: return 6'd17;  // l
      5'd12: return 6'd19;  // m
      5'd13: return 6'd21;  // n
      5'd15: return 6'd23;  // p
      5'd16: return 6'd25;  // q
      5'd17: return 6'd26;  // r
      5'd18: return 6'd28;  // s
      5'd19: return 6'd31;  // t
      5'd21: return 6'd33;  // v
      5'd22: return 6'd35;  // w
      5'd23: return 6'd36;  // x
      5'd24: return 6'd38;  // y
      5'd25: return 6'd39;  // z
      default: return rtk_pkg::ROW_EMPTY;
    endcase
  endfunction

  function automatic int vowel_column(input logic [4:0] code);
    case (code)
      KEY_A:   return 0;
      KEY_I:   return 1;
      KEY_U:   return 2;
      KEY_E:   return 3;
      KEY_O:   return 4;
      default: return -1;
    endcase
  endfunction

  // y rows sit right after their base row, except s which skips sh
  function automatic logic [5:0] row_with_y(input logic [5:0] row);
    case (row)
      6'd1, 6'd5, 6'd7, 6'd9, 6'd11, 6'd13, 6'd15, 6'd17, 6'd19, 6'd21, 6'd23,
      6'd26, 6'd31, 6'd33, 6'd36, 6'd39: return row + 6'd1;
      rtk_pkg::ROW_S: return 6'd30;
      default:        return rtk_pkg::ROW_EMPTY;
    endcase
  endfunction

  function automatic logic [5:0] row_after_backspace(input logic [5:0] row);
    case (row)
      6'd2, 6'd4, 6'd6, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd18, 6'd20, 6'd22,
      6'd24, 6'd27, 6'd29, 6'd32, 6'd34, 6'd37, 6'd40: return row - 6'd1;
      6'd30:   return rtk_pkg::ROW_S;
      default: return rtk_pkg::ROW_EMPTY;
    endcase
  endfunction

  task automatic predict_key(input rtk_pkg::in_word_t k);
    rtk_pkg::out_word_t r;
    logic [5:0]         nxt;
    int                 col;
    bit                 commit;
    r      = '0;
    commit = 1'b0;
    if (k.req_type) begin
      conv_on = 1'b0;
      cur_row = rtk_pkg::ROW_EMPTY;
      return;
    end
    if (!k.key_pressed) return;
    if (k.key_code == rtk_pkg::KEY_SPACE && k.ctrl_held) begin
      conv_on = !conv_on;
      if (!conv_on) begin
        cur_row         = rtk_pkg::ROW_EMPTY;
        r.preedit_valid = 1'b1;
      end
      r.converter_on = conv_on;
      kana_expected.push_back(r);
      return;
    end
    if (!conv_on) return;
    nxt = cur_row;
    if (k.key_code == rtk_pkg::KEY_BACKSPACE) begin
      nxt = row_after_backspace(cur_row);
    end else if (k.key_code < rtk_pkg::KEY_LETTERS) begin
      col = vowel_column(k.key_code);
      if (k.key_code == rtk_pkg::KEY_Y && row_with_y(cur_row) != rtk_pkg::ROW_EMPTY) begin
        nxt = row_with_y(cur_row);
      end else if (k.key_code == rtk_pkg::KEY_H &&
                   (cur_row == rtk_pkg::ROW_C || cur_row == rtk_pkg::ROW_S)) begin
        nxt = cur_row + 6'd1;
      end else if (cur_row == rtk_pkg::ROW_N) begin
        commit       = 1'b1;
        r.commit_row = rtk_pkg::ROW_N;
        if (col >= 0) begin
          r.commit_kind  = rtk_pkg::KIND_KANA;
          r.commit_vowel = col[2:0];
          nxt            = rtk_pkg::ROW_EMPTY;
        end else begin
          r.commit_kind = rtk_pkg::KIND_SYL_N;
          nxt = (k.key_code == rtk_pkg::KEY_N) ? rtk_pkg::ROW_EMPTY
                                                : row_of_letter(k.key_code);
        end
      end else if (col >= 0) begin
        commit         = 1'b1;
        r.commit_kind  = rtk_pkg::KIND_KANA;
        r.commit_row   = cur_row;
        r.commit_vowel = col[2:0];
        nxt            = rtk_pkg::ROW_EMPTY;
      end else begin
        // nothing to flush when no letters are pending
        if (cur_row != rtk_pkg::ROW_EMPTY) begin
          commit        = 1'b1;
          r.commit_kind = rtk_pkg::KIND_LATIN;
          r.commit_row  = cur_row;
        end
        nxt = row_of_letter(k.key_code);
      end
    end
    cur_row        = nxt;
    r.commit_valid = commit;
    if (cur_row != rtk_pkg::ROW_EMPTY || !commit) begin
      r.preedit_valid = 1'b1;
      r.preedit_row   = cur_row;
    end
    r.converter_on = conv_on;
    kana_expected.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  function automatic bit quiet_tail();
    return tail_phase && pending_keys.size() < TAIL_WORDS;
  endfunction

  // key word driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_key(in_data);
        void'(pending_keys.pop_front());
        keys_accepted++;
      end
      // a stalled word stays on the bus untouched
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_keys.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet_tail() && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_keys[0];
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (kana_expected.size() == 0) begin
          report_mismatch("result word with nothing pending", int'(out_data), 0);
        end else begin
          want_word = kana_expected.pop_front();
          check_field("commit_valid", out_data.commit_valid, want_word.commit_valid);
          check_field("commit_kind", out_data.commit_kind, want_word.commit_kind);
          check_field("commit_row", out_data.commit_row, want_word.commit_row);
          check_field("commit_vowel", out_data.commit_vowel, want_word.commit_vowel);
          check_field("preedit_valid", out_data.preedit_valid, want_word.preedit_valid);
          check_field("preedit_row", out_data.preedit_row, want_word.preedit_row);
          check_field("converter_on", out_data.converter_on, want_word.converter_on);
          if (want_word.commit_valid && want_word.commit_kind <= rtk_pkg::KIND_LATIN)
            kind_count[want_word.commit_kind]++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && keys_accepted >= HOLD_AFTER) begin
        // long hold so the output queue fills and backs up the input
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (!quiet_tail() && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 idle_cycles, kana_expected.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rtk_pkg::in_word_t w;
    int                pick;
    int                counted;
    bit                gen_on;
    bit                is_toggle;

    // directed: off, toggle, rows, y and h extensions, syllabic n, backspace
    pending_keys.push_back(key_word(KEY_A, 1'b1, 1'b0));          // press while off
    pending_keys.push_back(key_word(rtk_pkg::KEY_SPACE, 1'b1, 1'b1)); // turn on
    pending_keys.push_back(key_word(KEY_A, 1'b0, 1'b0));          // release
    pending_keys.push_back(key_word(KEY_K, 1'b1, 1'b0));          // consonant on empty row
    pending_keys.push_back(key_word(rtk_pkg::KEY_Y, 1'b1, 1'b0));
    pending_keys.push_back(key_word(rtk_pkg::KEY_BACKSPACE, 1'b1, 1'b0));
    pending_keys.push_back(key_word(KEY_A, 1'b1, 1'b0));
    pending_keys.push_back(key_word(rtk_pkg::KEY_N, 1'b1, 1'b0));
    pending_keys.push_back(key_word(rtk_pkg::KEY_N, 1'b1, 1'b0)); // nn
    pending_keys.push_back(key_word(rtk_pkg::KEY_N, 1'b1, 1'b0));
    pending_keys.push_back(key_word(KEY_K, 1'b1, 1'b0));          // n before consonant
    pending_keys.push_back(key_word(KEY_C, 1'b1, 1'b0));          // latin flush
    pending_keys.push_back(key_word(rtk_pkg::KEY_H, 1'b1, 1'b0));
    pending_keys.push_back(key_word(KEY_O, 1'b1, 1'b0));
    pending_keys.push_back(key_word(KEY_X, 1'b1, 1'b0));
    pending_keys.push_back(key_word(rtk_pkg::KEY_Y, 1'b1, 1'b0));
    pending_keys.push_back(key_word(rtk_pkg::KEY_Y, 1'b1, 1'b0)); // y that cannot extend
    pending_keys.push_back(key_word(KEY_Z, 1'b1, 1'b0));
    pending_keys.push_back(key_word(rtk_pkg::KEY_BACKSPACE, 1'b1, 1'b0)); // one letter row
    pending_keys.push_back(key_word(rtk_pkg::KEY_BACKSPACE, 1'b1, 1'b0)); // empty row
    pending_keys.push_back(key_word(rtk_pkg::KEY_SPACE, 1'b1, 1'b0));
    pending_keys.push_back(key_word(KEY_SYMBOL, 1'b1, 1'b0));
    pending_keys.push_back(key_word(KEY_CODE_MAX, 1'b1, 1'b1));   // ctrl ignored
    pending_keys.push_back(key_word(KEY_U, 1'b1, 1'b1));
    w = key_word(rtk_pkg::KEY_SPACE, 1'b1, 1'b1);
    w.req_type = 1'b1;                                            // reset event
    pending_keys.push_back(w);
    pending_keys.push_back(key_word(rtk_pkg::KEY_SPACE, 1'b1, 1'b1));
    pending_keys.push_back(key_word(rtk_pkg::KEY_N, 1'b1, 1'b0));
    pending_keys.push_back(key_word(rtk_pkg::KEY_SPACE, 1'b1, 1'b1)); // off clears row

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // sender pause until every result is back
    while (pending_keys.size() != 0) @(posedge clk);
    while (kana_expected.size() != 0) @(posedge clk);

    // random typing, mostly romaji-like while the converter is on
    gen_on  = 1'b0;
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      w = key_word(5'($urandom_range(0, 25)), 1'b1, $urandom_range(0, 7) == 0);
      if ((!gen_on && pick < 85) || (pick >= 2 && pick < 5)) begin
        w = key_word(rtk_pkg::KEY_SPACE, 1'b1, 1'b1);
      end else if (pick < 2) begin
        w.req_type    = 1'b1;
        w.key_code    = 5'($urandom_range(0, KEY_CODE_MAX));
        w.key_pressed = 1'($urandom);
        w.ctrl_held   = 1'($urandom);
      end else if (pick < 12) begin
        w.key_pressed = 1'b0;
        w.key_code    = 5'($urandom_range(0, KEY_CODE_MAX));
      end else if (pick < 18) begin
        w.key_code = rtk_pkg::KEY_BACKSPACE;
      end else if (pick < 23) begin
        w.key_code = 5'($urandom_range(rtk_pkg::KEY_SPACE, KEY_CODE_MAX));
        if (w.key_code == rtk_pkg::KEY_SPACE) w.ctrl_held = 1'b0;
      end else if (pick < 55) begin
        case ($urandom_range(0, 4))
          0:       w.key_code = KEY_A;
          1:       w.key_code = KEY_I;
          2:       w.key_code = KEY_U;
          3:       w.key_code = KEY_E;
          default: w.key_code = KEY_O;
        endcase
      end else if (pick < 70) begin
        case ($urandom_range(0, 2))
          0:       w.key_code = rtk_pkg::KEY_Y;
          1:       w.key_code = rtk_pkg::KEY_H;
          default: w.key_code = rtk_pkg::KEY_N;
        endcase
      end
      is_toggle = !w.req_type && w.key_pressed && w.key_code == rtk_pkg::KEY_SPACE &&
                  w.ctrl_held;
      if (w.req_type) gen_on = 1'b0;
      else if (is_toggle) gen_on = !gen_on;
      counted++;
      pending_keys.push_back(w);
    end
    tail_phase = 1'b1;

    while (pending_keys.size() != 0) @(posedge clk);
    while (kana_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d key words and %0d result words, with a long output hold",
             keys_accepted, results_checked);
    $display("commits seen: %0d kana, %0d syllabic n, %0d latin flush",
             kind_count[rtk_pkg::KIND_KANA], kind_count[rtk_pkg::KIND_SYL_N],
             kind_count[rtk_pkg::KIND_LATIN]);
    if (mismatches == 0 && kana_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/rtk_pkg.sv
hdl/rtk_step.sv
hdl/rtk_out_queue.sv
hdl/romaji_to_kana_converter.sv
tb/sv/tb_top.sv
